// ===== src/bcc_pkg.sv =====
// ----------------------------------------------------------------------------
// bcc_pkg
// Types and constants shared by the barycentric coordinate pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bcc_pkg;

	// coordinate width, signed Q12.4
	localparam int COORD_W  = 16;
	// signed determinant width, three products of a coordinate and a difference
	localparam int DET_W    = 2 * COORD_W + 3;
	// weight width, signed
	localparam int WEIGHT_W = 24;
	// quotient bits kept by the divider, one above the weight magnitude
	localparam int QUO_W    = WEIGHT_W + 1;

	typedef struct packed {
		logic signed [COORD_W-1:0] tri_ax;
		logic signed [COORD_W-1:0] tri_ay;
		logic signed [COORD_W-1:0] tri_bx;
		logic signed [COORD_W-1:0] tri_by;
		logic signed [COORD_W-1:0] tri_cx;
		logic signed [COORD_W-1:0] tri_cy;
		logic signed [COORD_W-1:0] query_x;
		logic signed [COORD_W-1:0] query_y;
	} in_item_t;

	typedef struct packed {
		logic signed [WEIGHT_W-1:0] weight_u;
		logic signed [WEIGHT_W-1:0] weight_v;
		logic signed [WEIGHT_W-1:0] weight_w;
		logic                       degenerate;
	} out_item_t;

	// determinant magnitudes and signs handed to the divider
	typedef struct packed {
		logic [DET_W-1:0] mag_a;
		logic [DET_W-1:0] mag_u;
		logic [DET_W-1:0] mag_v;
		logic             neg_u;
		logic             neg_v;
		logic             zero;
	} det_t;

	// quotient magnitudes handed to the output stage
	typedef struct packed {
		logic [QUO_W-1:0] q_u;
		logic [QUO_W-1:0] q_v;
		logic             sat_u;
		logic             sat_v;
		logic             neg_u;
		logic             neg_v;
		logic             zero;
	} quo_t;

	// signed weight from a quotient magnitude, capped at 2^24 then clamped
	function automatic logic signed [WEIGHT_W-1:0] sat_weight(
		input logic [QUO_W-1:0] q,
		input logic             sat,
		input logic             neg
	);
		logic [QUO_W-1:0] cap;
		logic [QUO_W-1:0] mag;
		logic [QUO_W-1:0] lim;
		logic [QUO_W-1:0] neg_mag;
		cap     = QUO_W'(1) << WEIGHT_W;
		lim     = QUO_W'(1) << (WEIGHT_W - 1);
		mag     = (sat || (q > cap)) ? cap : q;
		neg_mag = QUO_W'(0) - mag;
		if (neg) begin
			if (mag > lim) begin
				sat_weight = {1'b1, {(WEIGHT_W-1){1'b0}}};
			end else begin
				sat_weight = neg_mag[WEIGHT_W-1:0];
			end
		end else begin
			if (mag >= lim) begin
				sat_weight = {1'b0, {(WEIGHT_W-1){1'b1}}};
			end else begin
				sat_weight = mag[WEIGHT_W-1:0];
			end
		end
	endfunction

endpackage

`default_nettype wire

// ===== src/bcc_det.sv =====
// ----------------------------------------------------------------------------
// bcc_det
// Four-stage determinant front end: differences, products, sums, magnitudes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bcc_det (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic             in_valid,
	input  wire bcc_pkg::in_item_t in_item,
	output logic                  out_valid,
	output bcc_pkg::det_t         out_det
);

	localparam int CW = bcc_pkg::COORD_W;
	localparam int DW = bcc_pkg::DET_W;
	localparam int PW = 2 * CW + 1;

	logic                 vld_s1, vld_s2, vld_s3, vld_s4;

	// stage 1: coordinates and differences
	logic signed [CW-1:0] ax_s1, bx_s1, cx_s1, px_s1;
	logic signed [CW:0]   dbc_s1, dac_s1, dab_s1, dpc_s1, dpb_s1, dap_s1;

	// stage 2: nine products
	logic signed [PW-1:0] pa0_s2, pa1_s2, pa2_s2;
	logic signed [PW-1:0] pu0_s2, pu1_s2, pu2_s2;
	logic signed [PW-1:0] pv0_s2, pv1_s2, pv2_s2;

	// stage 3: determinants
	logic signed [DW-1:0] deta_s3, detu_s3, detv_s3;

	bcc_pkg::det_t        det_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1  <= in_item.tri_ax;
			bx_s1  <= in_item.tri_bx;
			cx_s1  <= in_item.tri_cx;
			px_s1  <= in_item.query_x;
			dbc_s1 <= (CW+1)'(in_item.tri_by)  - (CW+1)'(in_item.tri_cy);
			dac_s1 <= (CW+1)'(in_item.tri_ay)  - (CW+1)'(in_item.tri_cy);
			dab_s1 <= (CW+1)'(in_item.tri_ay)  - (CW+1)'(in_item.tri_by);
			dpc_s1 <= (CW+1)'(in_item.query_y) - (CW+1)'(in_item.tri_cy);
			dpb_s1 <= (CW+1)'(in_item.query_y) - (CW+1)'(in_item.tri_by);
			dap_s1 <= (CW+1)'(in_item.tri_ay)  - (CW+1)'(in_item.query_y);

			pa0_s2 <= PW'(ax_s1) * PW'(dbc_s1);
			pa1_s2 <= PW'(bx_s1) * PW'(dac_s1);
			pa2_s2 <= PW'(cx_s1) * PW'(dab_s1);
			pu0_s2 <= PW'(px_s1) * PW'(dbc_s1);
			pu1_s2 <= PW'(bx_s1) * PW'(dpc_s1);
			pu2_s2 <= PW'(cx_s1) * PW'(dpb_s1);
			pv0_s2 <= PW'(ax_s1) * PW'(dpc_s1);
			pv1_s2 <= PW'(px_s1) * PW'(dac_s1);
			pv2_s2 <= PW'(cx_s1) * PW'(dap_s1);

			deta_s3 <= DW'(pa0_s2) - DW'(pa1_s2) + DW'(pa2_s2);
			detu_s3 <= DW'(pu0_s2) - DW'(pu1_s2) + DW'(pu2_s2);
			detv_s3 <= DW'(pv0_s2) - DW'(pv1_s2) + DW'(pv2_s2);

			det_s4.mag_a <= deta_s3[DW-1] ? DW'(0) - deta_s3 : deta_s3;
			det_s4.mag_u <= detu_s3[DW-1] ? DW'(0) - detu_s3 : detu_s3;
			det_s4.mag_v <= detv_s3[DW-1] ? DW'(0) - detv_s3 : detv_s3;
			det_s4.neg_u <= detu_s3[DW-1] ^ deta_s3[DW-1];
			det_s4.neg_v <= detv_s3[DW-1] ^ deta_s3[DW-1];
			det_s4.zero  <= (deta_s3 == '0);
		end
	end

	assign out_valid = vld_s4;
	assign out_det   = det_s4;

endmodule

`default_nettype wire

// ===== src/bcc_div.sv =====
// ----------------------------------------------------------------------------
// bcc_div
// Pipelined restoring divider, one quotient bit per stage for u and v.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bcc_div #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          in_valid,
	input  wire bcc_pkg::det_t in_det,
	output logic               out_valid,
	output bcc_pkg::quo_t      out_quo
);

	localparam int DW   = bcc_pkg::DET_W;
	localparam int QB   = bcc_pkg::QUO_W;
	localparam int NW   = DW + FRAC_BITS;
	localparam int CMPW = NW + QB;

	logic          vld [0:QB];
	logic [NW-1:0] ru  [0:QB];
	logic [NW-1:0] rv  [0:QB];
	logic [QB-1:0] qu  [0:QB];
	logic [QB-1:0] qv  [0:QB];
	logic [DW-1:0] dm  [0:QB];
	logic          su  [0:QB];
	logic          sv  [0:QB];
	logic          nu  [0:QB];
	logic          nv  [0:QB];
	logic          zr  [0:QB];

	logic [NW-1:0]   num_u, num_v;
	logic [CMPW-1:0] dtop;

	// scaled numerators, saturation when the quotient reaches 2^QB
	assign num_u = NW'(in_det.mag_u) << FRAC_BITS;
	assign num_v = NW'(in_det.mag_v) << FRAC_BITS;
	assign dtop  = CMPW'(in_det.mag_a) << QB;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld[0] <= 1'b0;
		end else if (en) begin
			vld[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ru[0] <= num_u;
			rv[0] <= num_v;
			qu[0] <= '0;
			qv[0] <= '0;
			dm[0] <= in_det.mag_a;
			su[0] <= (CMPW'(num_u) >= dtop);
			sv[0] <= (CMPW'(num_v) >= dtop);
			nu[0] <= in_det.neg_u;
			nv[0] <= in_det.neg_v;
			zr[0] <= in_det.zero;
		end
	end

	for (genvar j = 1; j <= QB; j++) begin : g_bit
		logic [CMPW-1:0] dsh;
		logic [CMPW-1:0] du, dv;
		logic            bu, bv;

		assign dsh = CMPW'(dm[j-1]) << (QB - j);
		assign bu  = (CMPW'(ru[j-1]) >= dsh);
		assign bv  = (CMPW'(rv[j-1]) >= dsh);
		assign du  = CMPW'(ru[j-1]) - dsh;
		assign dv  = CMPW'(rv[j-1]) - dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld[j] <= 1'b0;
			end else if (en) begin
				vld[j] <= vld[j-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ru[j] <= bu ? du[NW-1:0] : ru[j-1];
				rv[j] <= bv ? dv[NW-1:0] : rv[j-1];
				qu[j] <= {qu[j-1][QB-2:0], bu};
				qv[j] <= {qv[j-1][QB-2:0], bv};
				dm[j] <= dm[j-1];
				su[j] <= su[j-1];
				sv[j] <= sv[j-1];
				nu[j] <= nu[j-1];
				nv[j] <= nv[j-1];
				zr[j] <= zr[j-1];
			end
		end
	end

	assign out_valid     = vld[QB];
	assign out_quo.q_u   = qu[QB];
	assign out_quo.q_v   = qv[QB];
	assign out_quo.sat_u = su[QB];
	assign out_quo.sat_v = sv[QB];
	assign out_quo.neg_u = nu[QB];
	assign out_quo.neg_v = nv[QB];
	assign out_quo.zero  = zr[QB];

endmodule

`default_nettype wire

// ===== src/barycentric_coords_2d.sv =====
// ----------------------------------------------------------------------------
// barycentric_coords_2d
// Barycentric weights of a 2D query point by Cramer's rule, fully pipelined.
// ----------------------------------------------------------------------------
//
//  channel | signals                          | payload
//  --------+----------------------------------+------------------------------
//  input   | item_valid / item_ready          | item   (triangle, query point)
//  output  | result_valid / result_ready      | result (u, v, w, degenerate)
//
//  one item enters per cycle unless the pipeline holds; 4 determinant stages,
//  1 saturation check, 25 quotient bit stages, 1 output register
//  the pipeline advances as a whole; it holds only while the output
//  register is full and result_ready is low
//  arst_n clears the valid bits only; payload registers are not reset
//
`timescale 1ns / 1ps
`default_nettype none

module barycentric_coords_2d #(
	parameter int WEIGHT_FRAC_BITS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	output logic                    item_ready,
	input  wire bcc_pkg::in_item_t  item,
	output logic                    result_valid,
	input  wire logic               result_ready,
	output bcc_pkg::out_item_t      result
);

	localparam int WW = bcc_pkg::WEIGHT_W;
	// width of one minus u minus v before clamping
	localparam int SW = WW + 3;

	logic               adv;
	logic               det_vld;
	bcc_pkg::det_t      det;
	logic               quo_vld;
	bcc_pkg::quo_t      quo;

	logic signed [WW-1:0] u_c, v_c;
	logic signed [SW-1:0] w_sum;
	logic signed [WW-1:0] w_c;

	logic               out_vld_q;
	bcc_pkg::out_item_t out_q;

	// whole pipe moves unless a finished result is stuck at the output
	assign adv        = !out_vld_q || result_ready;
	assign item_ready = adv;

	bcc_det u_det (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (item_valid),
		.in_item   (item),
		.out_valid (det_vld),
		.out_det   (det)
	);

	bcc_div #(
		.FRAC_BITS (WEIGHT_FRAC_BITS)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (det_vld),
		.in_det    (det),
		.out_valid (quo_vld),
		.out_quo   (quo)
	);

	// sign, cap and clamp of u and v, then w from the clamped values
	always_comb begin
		u_c   = bcc_pkg::sat_weight(quo.q_u, quo.sat_u, quo.neg_u);
		v_c   = bcc_pkg::sat_weight(quo.q_v, quo.sat_v, quo.neg_v);
		w_sum = (SW'(1) << WEIGHT_FRAC_BITS) - SW'(u_c) - SW'(v_c);
		if (w_sum > $signed(SW'({1'b0, {(WW-1){1'b1}}}))) begin
			w_c = {1'b0, {(WW-1){1'b1}}};
		end else if (w_sum < -(SW'(1) << (WW - 1))) begin
			w_c = {1'b1, {(WW-1){1'b0}}};
		end else begin
			w_c = w_sum[WW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= quo_vld;
		end
	end

	// degenerate triangle forces zero weights
	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.weight_u   <= quo.zero ? '0 : u_c;
			out_q.weight_v   <= quo.zero ? '0 : v_c;
			out_q.weight_w   <= quo.zero ? '0 : w_c;
			out_q.degenerate <= quo.zero;
		end
	end

	assign result_valid = out_vld_q;
	assign result       = out_q;

endmodule

`default_nettype wire

// ===== src/bcc_checker.sv =====
// ----------------------------------------------------------------------------
// bcc_checker
// Port-level checks on the barycentric coordinate block, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bcc_checker #(
	parameter int WEIGHT_FRAC_BITS = 16
) (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               item_valid,
	input wire logic               item_ready,
	input wire bcc_pkg::in_item_t  item,
	input wire logic               result_valid,
	input wire logic               result_ready,
	input wire bcc_pkg::out_item_t result
);

	localparam int WW = bcc_pkg::WEIGHT_W;
	localparam logic signed [WW:0] ONE_W = (WW+1)'(1) << WEIGHT_FRAC_BITS;
	localparam logic signed [WW:0] MAX_W = (WW+1)'({1'b0, {(WW-1){1'b1}}});
	localparam logic signed [WW-1:0] ONE_SAT =
		(ONE_W > MAX_W) ? MAX_W[WW-1:0] : ONE_W[WW-1:0];

	logic unused_in;
	assign unused_in = item_valid ^ (^item);

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		(!result_valid || result_ready) |-> item_ready)
		else $error("input blocked with free output");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.degenerate |->
			result.weight_u == '0 && result.weight_v == '0 && result.weight_w == '0)
		else $error("degenerate result with nonzero weight");

	a_w_one: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.degenerate && result.weight_u == '0 &&
			result.weight_v == '0 |-> result.weight_w == ONE_SAT)
		else $error("w is not one when u and v are zero");

endmodule

bind barycentric_coords_2d bcc_checker #(
	.WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
) u_bcc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_ready   (item_ready),
	.item         (item),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);

`default_nettype wire

// ===== tb/tb_barycentric_coords_2d.sv =====
// ----------------------------------------------------------------------------
// tb_barycentric_coords_2d
// Streams triangles and query points through the weight pipeline and checks
// every result against a predictor built from exact determinant arithmetic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

class weight_scoreboard;
	bcc_pkg::out_item_t pending_weights[$];
	int unsigned mismatches;

	// num * 2^16 / den truncated toward zero, clamped to 24 bits signed
	static function longint cramer_quotient(longint num, longint den);
		longint n;
		longint d;
		longint q;
		n = (num < 0) ? -num : num;
		d = (den < 0) ? -den : den;
		// 2^24 cap fits easily; shift stays under 64 bits for 35-bit numerators
		q = (n <<< 16) / d;
		if (q > (64'sd1 <<< 24)) begin
			q = 64'sd1 <<< 24;
		end
		if ((num < 0) != (den < 0)) begin
			q = -q;
		end
		return clamp24(q);
	endfunction

	static function longint clamp24(longint x);
		if (x > 64'sd8388607) begin
			return 64'sd8388607;
		end
		if (x < -64'sd8388608) begin
			return -64'sd8388608;
		end
		return x;
	endfunction

	function void note_item(bcc_pkg::in_item_t it);
		longint ax, ay, bx, by, cx, cy, px, py;
		longint det_a, det_u, det_v, u, v, w;
		bcc_pkg::out_item_t exp_r;
		ax = it.tri_ax; ay = it.tri_ay;
		bx = it.tri_bx; by = it.tri_by;
		cx = it.tri_cx; cy = it.tri_cy;
		px = it.query_x; py = it.query_y;
		det_a = ax * (by - cy) - bx * (ay - cy) + cx * (ay - by);
		det_u = px * (by - cy) - bx * (py - cy) + cx * (py - by);
		det_v = ax * (py - cy) - px * (ay - cy) + cx * (ay - py);
		if (det_a == 0) begin
			exp_r = '0;
			exp_r.degenerate = 1'b1;
		end else begin
			u = cramer_quotient(det_u, det_a);
			v = cramer_quotient(det_v, det_a);
			w = clamp24((64'sd1 <<< 16) - u - v);
			exp_r.weight_u = u[23:0];
			exp_r.weight_v = v[23:0];
			exp_r.weight_w = w[23:0];
			exp_r.degenerate = 1'b0;
		end
		pending_weights.push_back(exp_r);
	endfunction

	function void check_result(bcc_pkg::out_item_t got);
		bcc_pkg::out_item_t exp_r;
		if (pending_weights.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("unexpected result %h", got);
			end
			return;
		end
		exp_r = pending_weights.pop_front();
		if (got.weight_u !== exp_r.weight_u || got.weight_v !== exp_r.weight_v ||
				got.weight_w !== exp_r.weight_w || got.degenerate !== exp_r.degenerate) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("mismatch: exp u=%h v=%h w=%h deg=%b got u=%h v=%h w=%h deg=%b",
					exp_r.weight_u, exp_r.weight_v, exp_r.weight_w, exp_r.degenerate,
					got.weight_u, got.weight_v, got.weight_w, got.degenerate);
			end
		end
	endfunction
endclass

module tb_barycentric_coords_2d;

	localparam int LATENCY     = 31;
	localparam int STALL_LIMIT = 5000;
	localparam int NUM_RANDOM  = 800;

	logic               clk;
	logic               arst_n;
	logic               item_valid;
	logic               item_ready;
	bcc_pkg::in_item_t  item;
	logic               result_valid;
	logic               result_ready;
	bcc_pkg::out_item_t result;

	weight_scoreboard sb;
	int unsigned idle_cycles;

	barycentric_coords_2d DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 60);
	endfunction

	// random coordinate, biased toward extremes and small values
	function automatic logic [bcc_pkg::COORD_W-1:0] rand_coord();
		case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'($signed($urandom_range(0, 64)) - 32);
			3: return 16'($signed($urandom_range(0, 8192)) - 4096);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic bcc_pkg::in_item_t make_item(int kind);
		bcc_pkg::in_item_t it;
		it = {rand_coord(), rand_coord(), rand_coord(), rand_coord(),
			rand_coord(), rand_coord(), rand_coord(), rand_coord()};
		case (kind)
			// collinear vertices: degenerate triangle
			0: begin
				it.tri_bx = it.tri_ax;
				it.tri_by = it.tri_ay;
			end
			// query on a vertex
			1: begin
				it.query_x = it.tri_cx;
				it.query_y = it.tri_cy;
			end
			// tiny triangle with distant query: weight saturation
			2: begin
				it.tri_bx = it.tri_ax + 16'sd1;
				it.tri_by = it.tri_ay;
				it.tri_cx = it.tri_ax;
				it.tri_cy = it.tri_ay + 16'sd1;
			end
			default: ;
		endcase
		return it;
	endfunction

	// hold valid until the transfer happens
	task automatic send_item(bcc_pkg::in_item_t it);
		item_valid <= 1'b1;
		item       <= it;
		do @(posedge clk); while (!item_ready);
		sb.note_item(it);
	endtask

	task automatic send_gap();
		int g;
		g = gap_len();
		if (g > 0) begin
			item_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	// result side: random backpressure, check on each transfer
	initial begin
		int g;
		result_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			g = gap_len();
			result_ready <= (g == 0);
			if (g > 0) begin
				repeat (g) @(posedge clk);
				result_ready <= 1'b1;
			end
			@(posedge clk);
			if (result_valid && result_ready) begin
				sb.check_result(result);
			end
		end
	end

	// watchdog on cycles with no transfer
	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= STALL_LIMIT) begin
			$display("barycentric_coords_2d test failed");
			$finish;
		end
	end

	initial begin
		bcc_pkg::in_item_t it;
		int waited;
		sb          = new();
		arst_n      = 1'b0;
		item_valid  = 1'b0;
		item        = '0;
		idle_cycles = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, degenerate cases, vertex hits, saturation
		send_item('0);
		send_item('1);
		send_item({16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff,
			16'h7fff, 16'h7fff});
		send_item({16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000,
			16'h8000, 16'h8000});
		send_item({16'sd0, 16'sd0, 16'sd16, 16'sd0, 16'sd0, 16'sd16, 16'sd4, 16'sd4});
		send_item({16'sd0, 16'sd0, 16'sd16, 16'sd0, 16'sd0, 16'sd16, 16'sd16, 16'sd0});
		send_item({16'sd0, 16'sd0, 16'sd16, 16'sd0, 16'sd0, 16'sd16, 16'sd0, 16'sd0});
		send_item({16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd1, 16'h7fff, 16'h8000});
		send_item({16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd1, 16'h8000, 16'h7fff});
		send_item({16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd1, 16'h8000, 16'h8000});
		send_item({16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd1, 16'sd128, 16'sd0});
		send_item({16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd1, -16'sd128, 16'sd0});
		send_item({16'sd0, 16'sd0, 16'sd8, 16'sd8, 16'sd16, 16'sd16, 16'sd3, 16'sd5});
		send_item({16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd0, 16'sd0});
		for (int k = 0; k < 4; k++) begin
			send_item(make_item(k));
		end
		item_valid <= 1'b0;

		// drain completely before the random part
		waited = 0;
		while (sb.pending_weights.size() != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end

		for (int n = 0; n < NUM_RANDOM; n++) begin
			it = make_item($urandom_range(0, 9));
			send_item(it);
			if ($urandom_range(0, 3) != 0) begin
				send_gap();
			end
		end
		item_valid <= 1'b0;

		while (sb.pending_weights.size() != 0) begin
			@(posedge clk);
		end
		repeat (LATENCY + 10) @(posedge clk);

		if (sb.mismatches == 0 && sb.pending_weights.size() == 0) begin
			$display("barycentric_coords_2d test passed");
		end else begin
			$display("barycentric_coords_2d test failed");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== sim.f =====
src/bcc_pkg.sv
src/bcc_det.sv
src/bcc_div.sv
src/barycentric_coords_2d.sv
src/bcc_checker.sv
tb/tb_barycentric_coords_2d.sv
